FILE: sv/pdrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrc_pkg
// Shared types and constants of the palette delta run classifier.
// ----------------------------------------------------------------------------
package pdrc_pkg;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_RFLAG = 6'b000100,
      ST_MAP   = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_LFLAG = 6'b100000
   } state_type;

   // input actions
   localparam logic [1:0] ACT_MAP_WRITE = 2'd0;
   localparam logic [1:0] ACT_PIXEL     = 2'd1;
   localparam logic [1:0] ACT_NEW_FRAME = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_RUN_FLAG  = 2'd0;
   localparam logic [1:0] KIND_LINE_FLAG = 2'd1;
   localparam logic [1:0] KIND_SYMBOL    = 2'd2;

   // tier selectors
   localparam logic [1:0] SEL_P2  = 2'd0;
   localparam logic [1:0] SEL_P4  = 2'd1;
   localparam logic [1:0] SEL_P8  = 2'd2;
   localparam logic [1:0] SEL_RAW = 2'd3;

   // symbol widths
   localparam logic [4:0] BITS_FLAG = 5'd0;
   localparam logic [4:0] BITS_P2   = 5'd2;
   localparam logic [4:0] BITS_P4   = 5'd4;
   localparam logic [4:0] BITS_P8   = 5'd8;
   localparam logic [4:0] BITS_RAW  = 5'd16;

   // palette map
   localparam int         PAL_DEPTH = 65536;
   localparam logic [8:0] PAL_RAW   = 9'd276;
   localparam logic [8:0] P4_BASE   = 9'd4;
   localparam logic [8:0] P8_BASE   = 9'd20;

   // configuration register indexes
   localparam logic CSR_LINE_WIDTH = 1'b0;
   localparam logic CSR_RUN_SIZE   = 1'b1;

   localparam logic [12:0] LINE_WIDTH_RESET = 13'd320;
   localparam logic [5:0]  RUN_SIZE_RESET   = 6'd16;

   // RGBA8888 to RGB565
   function automatic logic [15:0] to565(input logic [31:0] px);
      return {px[31:27], px[23:18], px[15:11]};
   endfunction

endpackage

FILE: sv/pdrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrc_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pdrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/palette_delta_run_classifier.sv
`timescale 1ns / 1ps
// Flow: a pixel that ends no run, a map write or a frame start is taken while idle. A pixel
// that ends a run is followed by its run flag, then, for a changed run, each symbol (store
// read, then map read) and, at a line end, a line flag, all held by any output stall.
// Reset: synchronous; afterwards a sweep writes "raw" to every palette map entry,
// during which req_stall stays high. Registers reset to line_width 320, run size 16.
// ----------------------------------------------------------------------------
// palette_delta_run_classifier
// Reduces current/previous pixels to RGB565, buffers one run, emits run and
// line change flags and, for changed runs, one palette-tiered symbol per pixel.
// ----------------------------------------------------------------------------
module palette_delta_run_classifier #(
   parameter int MAX_RUN   = 32,
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,

   // input beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_map_color,
   input  logic [8:0]  req_map_index,
   input  logic [31:0] req_current_pixel,
   input  logic [31:0] req_previous_pixel,

   // result beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic        rsp_flag,
   output logic [1:0]  rsp_selector,
   output logic [15:0] rsp_symbol,
   output logic [4:0]  rsp_sym_width,
   output logic        rsp_last,

   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);

   // run counters hold 0..MAX_RUN; store address covers 0..MAX_RUN-1
   localparam int RW = $clog2(MAX_RUN + 1);
   localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
   // column counter holds 0..MAX_WIDTH
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam logic [16:0] MaxWidth17 = 17'(MAX_WIDTH);
   localparam logic [6:0]  MaxRun7    = 7'(MAX_RUN);

   pdrc_pkg::state_type state_ff, state_in;

   logic [15:0]   clr_cnt_ff, clr_cnt_in;
   logic [12:0]   line_width_ff;
   logic [5:0]    run_size_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] run_pos_ff, run_pos_in;
   logic          run_diff_ff, run_diff_in;
   logic          line_diff_ff, line_diff_in;

   // snapshot of a finished run, used while its results drain
   logic          rflag_ff, rflag_in;
   logic          line_end_ff, line_end_in;
   logic          lflag_ff, lflag_in;
   logic [RW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] sym_idx_ff, sym_idx_in;
   logic [15:0]   color_ff, color_in;

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [1:0]    kind_ff, kind_in;
   logic          flag_ff, flag_in;
   logic [1:0]    sel_ff, sel_in;
   logic [15:0]   symbol_ff, symbol_in;
   logic [4:0]    bits_ff, bits_in;
   logic          last_ff, last_in;

   // memory ports
   logic          store_wr_en, store_rd_en;
   logic [AW-1:0] store_rd_addr;
   logic [15:0]   store_rd_data;
   logic          pal_wr_en, pal_rd_en;
   logic [15:0]   pal_wr_addr;
   logic [8:0]    pal_wr_data;
   logic [8:0]    pal_rd_data;

   logic          accept, out_free;
   logic [CW-1:0] width_eff;
   logic [RW-1:0] run_eff;
   logic [16:0]   lw17;
   logic [6:0]    rl7;
   logic [15:0]   cur565, prev565;
   logic [CW-1:0] col_next;
   logic [RW-1:0] run_next;
   logic          diff_next, line_end, run_end, line_diff_acc;
   logic [RW-1:0] idx_next;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != pdrc_pkg::ST_IDLE);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // effective register values: zero acts as one, oversize clamps to the maximum
   assign lw17 = {4'd0, line_width_ff};
   assign rl7  = {1'b0, run_size_ff};
   assign width_eff = (lw17 == 17'd0) ? CW'(1) :
                      (lw17 > MaxWidth17) ? CW'(MAX_WIDTH) : CW'(lw17);
   assign run_eff   = (rl7 == 7'd0) ? RW'(1) :
                      (rl7 > MaxRun7) ? RW'(MAX_RUN) : RW'(rl7);

   assign cur565   = pdrc_pkg::to565(req_current_pixel);
   assign prev565  = pdrc_pkg::to565(req_previous_pixel);
   // positions stay below their limits before the increment, so these never wrap
   assign col_next = col_ff + 1'b1;
   assign run_next = run_pos_ff + 1'b1;
   assign diff_next     = run_diff_ff || (cur565 != prev565);
   assign line_end      = (col_next >= width_eff);
   assign run_end       = line_end || (run_next >= run_eff);
   assign line_diff_acc = line_diff_ff || diff_next;
   assign idx_next      = sym_idx_ff + 1'b1;

   // run store: written with each pixel, read back at the end of the run
   assign store_wr_en = accept && (req_action == pdrc_pkg::ACT_PIXEL);

   pdrc_ram #(
      .WIDTH(16),
      .DEPTH(MAX_RUN)
   ) u_run_store (
      .clock  (clock),
      .wr_en  (store_wr_en),
      .wr_addr(run_pos_ff[AW-1:0]),
      .wr_data(cur565),
      .rd_en  (store_rd_en),
      .rd_addr(store_rd_addr),
      .rd_data(store_rd_data)
   );

   // palette map: cleared by the reset sweep, loaded by map writes,
   // looked up with the stored color as address
   assign pal_wr_en   = (state_ff == pdrc_pkg::ST_CLEAR) ||
                        (accept && (req_action == pdrc_pkg::ACT_MAP_WRITE));
   assign pal_wr_addr = (state_ff == pdrc_pkg::ST_CLEAR) ? clr_cnt_ff : req_map_color;
   assign pal_wr_data = (state_ff == pdrc_pkg::ST_CLEAR) ? pdrc_pkg::PAL_RAW : req_map_index;

   pdrc_ram #(
      .WIDTH(9),
      .DEPTH(pdrc_pkg::PAL_DEPTH)
   ) u_palette_map (
      .clock  (clock),
      .wr_en  (pal_wr_en),
      .wr_addr(pal_wr_addr),
      .wr_data(pal_wr_data),
      .rd_en  (pal_rd_en),
      .rd_addr(store_rd_data),
      .rd_data(pal_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      col_in       = col_ff;
      run_pos_in   = run_pos_ff;
      run_diff_in  = run_diff_ff;
      line_diff_in = line_diff_ff;
      rflag_in     = rflag_ff;
      line_end_in  = line_end_ff;
      lflag_in     = lflag_ff;
      cnt_in       = cnt_ff;
      sym_idx_in   = sym_idx_ff;
      color_in     = color_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      flag_in      = flag_ff;
      sel_in       = sel_ff;
      symbol_in    = symbol_ff;
      bits_in      = bits_ff;
      last_in      = last_ff;
      store_rd_en   = 1'b0;
      store_rd_addr = '0;
      pal_rd_en     = 1'b0;

      unique case (state_ff)
         pdrc_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == 16'hffff) begin
               state_in = pdrc_pkg::ST_IDLE;
            end
         end

         pdrc_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  pdrc_pkg::ACT_PIXEL: begin
                     if (run_end) begin
                        // snapshot the run, then drain its results
                        rflag_in    = diff_next;
                        cnt_in      = run_next;
                        line_end_in = line_end;
                        run_pos_in  = '0;
                        run_diff_in = 1'b0;
                        state_in    = pdrc_pkg::ST_RFLAG;
                        if (line_end) begin
                           lflag_in     = line_diff_acc;
                           col_in       = '0;
                           line_diff_in = 1'b0;
                        end else begin
                           col_in       = col_next;
                           line_diff_in = line_diff_acc;
                        end
                     end else begin
                        run_pos_in  = run_next;
                        col_in      = col_next;
                        run_diff_in = diff_next;
                     end
                  end
                  pdrc_pkg::ACT_NEW_FRAME: begin
                     col_in       = '0;
                     run_pos_in   = '0;
                     run_diff_in  = 1'b0;
                     line_diff_in = 1'b0;
                  end
                  default: begin
                     // map write goes straight to the RAM; action 3 is ignored
                  end
               endcase
            end
         end

         pdrc_pkg::ST_RFLAG: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               kind_in      = pdrc_pkg::KIND_RUN_FLAG;
               flag_in      = rflag_ff;
               sel_in       = 2'd0;
               symbol_in    = 16'd0;
               bits_in      = pdrc_pkg::BITS_FLAG;
               last_in      = !rflag_ff && !line_end_ff;
               if (rflag_ff) begin
                  store_rd_en   = 1'b1;
                  store_rd_addr = '0;
                  sym_idx_in    = '0;
                  state_in      = pdrc_pkg::ST_MAP;
               end else if (line_end_ff) begin
                  state_in = pdrc_pkg::ST_LFLAG;
               end else begin
                  state_in = pdrc_pkg::ST_IDLE;
               end
            end
         end

         pdrc_pkg::ST_MAP: begin
            // stored color addresses the palette map
            pal_rd_en = 1'b1;
            color_in  = store_rd_data;
            state_in  = pdrc_pkg::ST_EMIT;
         end

         pdrc_pkg::ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               kind_in      = pdrc_pkg::KIND_SYMBOL;
               flag_in      = 1'b0;
               last_in      = (idx_next >= cnt_ff) && !line_end_ff;
               if (pal_rd_data < pdrc_pkg::P4_BASE) begin
                  sel_in    = pdrc_pkg::SEL_P2;
                  symbol_in = 16'(pal_rd_data);
                  bits_in   = pdrc_pkg::BITS_P2;
               end else if (pal_rd_data < pdrc_pkg::P8_BASE) begin
                  sel_in    = pdrc_pkg::SEL_P4;
                  symbol_in = 16'(pal_rd_data - pdrc_pkg::P4_BASE);
                  bits_in   = pdrc_pkg::BITS_P4;
               end else if (pal_rd_data < pdrc_pkg::PAL_RAW) begin
                  sel_in    = pdrc_pkg::SEL_P8;
                  symbol_in = 16'(pal_rd_data - pdrc_pkg::P8_BASE);
                  bits_in   = pdrc_pkg::BITS_P8;
               end else begin
                  sel_in    = pdrc_pkg::SEL_RAW;
                  symbol_in = color_ff;
                  bits_in   = pdrc_pkg::BITS_RAW;
               end
               // fetch the next stored color while this symbol goes out
               if (idx_next < cnt_ff) begin
                  store_rd_en   = 1'b1;
                  store_rd_addr = idx_next[AW-1:0];
                  sym_idx_in    = idx_next;
                  state_in      = pdrc_pkg::ST_MAP;
               end else if (line_end_ff) begin
                  state_in = pdrc_pkg::ST_LFLAG;
               end else begin
                  state_in = pdrc_pkg::ST_IDLE;
               end
            end
         end

         pdrc_pkg::ST_LFLAG: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               kind_in      = pdrc_pkg::KIND_LINE_FLAG;
               flag_in      = lflag_ff;
               sel_in       = 2'd0;
               symbol_in    = 16'd0;
               bits_in      = pdrc_pkg::BITS_FLAG;
               last_in      = 1'b1;
               state_in     = pdrc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pdrc_pkg::ST_CLEAR;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pdrc_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         line_width_ff <= pdrc_pkg::LINE_WIDTH_RESET;
         run_size_ff   <= pdrc_pkg::RUN_SIZE_RESET;
         col_ff        <= '0;
         run_pos_ff    <= '0;
         run_diff_ff   <= 1'b0;
         line_diff_ff  <= 1'b0;
         sym_idx_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         col_ff       <= col_in;
         run_pos_ff   <= run_pos_in;
         run_diff_ff  <= run_diff_in;
         line_diff_ff <= line_diff_in;
         sym_idx_ff   <= sym_idx_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               pdrc_pkg::CSR_LINE_WIDTH: line_width_ff <= csr_data;
               pdrc_pkg::CSR_RUN_SIZE:   run_size_ff   <= csr_data[5:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rflag_ff    <= rflag_in;
      line_end_ff <= line_end_in;
      lflag_ff    <= lflag_in;
      cnt_ff      <= cnt_in;
      color_ff    <= color_in;
      kind_ff     <= kind_in;
      flag_ff     <= flag_in;
      sel_ff      <= sel_in;
      symbol_ff   <= symbol_in;
      bits_ff     <= bits_in;
      last_ff     <= last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_flag      = flag_ff;
   assign rsp_selector  = sel_ff;
   assign rsp_symbol    = symbol_ff;
   assign rsp_sym_width = bits_ff;
   assign rsp_last      = last_ff;

endmodule
